FILE: hw/rtl/dlm_pkg.sv
// shared types and constants of the dense layer matrix-vector block
`default_nettype none

package dlm_pkg;

  // store dimensions
  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 16;
  localparam int ROW_LIM  = (MAX_ROWS < 16) ? MAX_ROWS : 16;
  localparam int WDEPTH   = MAX_ROWS * MAX_COLS;
  localparam int WADDR_W  = $clog2(WDEPTH);

  // field widths
  localparam int CMD_W  = 2;
  localparam int ROW_W  = 4;
  localparam int COL_W  = 4;
  localparam int VAL_W  = 16;
  localparam int CFG_W  = 5;
  localparam int CNT_W  = 5;
  localparam int IDX_W  = 2;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 48;
  localparam int OUT_W  = 32;
  localparam int FRAC_SHIFT = 8;

  // stream data widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  // request kinds
  localparam logic [CMD_W-1:0] CMD_WEIGHT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BIAS   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ELEM   = 2'd2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [IDX_W-1:0] CFG_COLS = 2'd1;

  // reset values of the configuration registers
  localparam logic [CFG_W-1:0] ROWS_RST = 5'd16;
  localparam logic [CFG_W-1:0] COLS_RST = 5'd16;

  // controller to datapath commands
  typedef struct packed {
    logic             take;
    logic             load_x;
    logic             acc_issue;
    logic [ROW_W-1:0] row;
    logic             cnt_inc;
    logic             out_load;
    logic             out_mism;
    logic             out_last;
    logic             vec_clear;
  } dlm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic             acc_en;
    logic             pipe_busy;
    logic             match;
    logic             out_free;
    logic [ROW_W-1:0] last_row;
  } dlm_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dlm_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module dlm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/dlm_ctrl.sv
// controller state machine of the dense layer block
`default_nettype none

module dlm_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [dlm_pkg::CMD_W-1:0] in_cmd_i,
  input  logic                      in_last_i,
  output logic                      in_ready_o,
  output dlm_pkg::dlm_cmd_t         cmd_o,
  input  dlm_pkg::dlm_sts_t         sts_i
);
  import dlm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_CHECK,
    S_EMIT,
    S_MISM
  } state_e;

  state_e           state_q, state_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             last_q, last_d;
  logic             take;

  assign take       = in_valid_i && (state_q == S_IDLE);
  assign in_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d      = state_q;
    row_d        = row_q;
    last_d       = last_q;
    cmd_o        = '0;
    cmd_o.take   = take;
    cmd_o.row    = row_q;
    unique case (state_q)
      S_IDLE: begin
        if (take && (in_cmd_i == CMD_ELEM)) begin
          last_d       = in_last_i;
          cmd_o.load_x = 1'b1;
          row_d        = '0;
          state_d      = sts_i.acc_en ? S_MAC : S_CHECK;
        end
      end
      S_MAC: begin
        cmd_o.acc_issue = 1'b1;
        if (row_q == sts_i.last_row) begin
          state_d = S_DRAIN;
        end else begin
          row_d = row_q + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.cnt_inc = 1'b1;
        row_d         = '0;
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (sts_i.match) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_MISM;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (row_q == sts_i.last_row) begin
            cmd_o.out_last  = 1'b1;
            cmd_o.vec_clear = 1'b1;
            state_d         = S_IDLE;
          end else begin
            row_d = row_q + 1'b1;
          end
        end
      end
      S_MISM: begin
        if (sts_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_mism  = 1'b1;
          cmd_o.out_last  = 1'b1;
          cmd_o.vec_clear = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and row counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      row_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      last_q  <= last_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dlm_dp.sv
// datapath: weight ram, bias and accumulator registers, shared mac, output register
`default_nettype none

module dlm_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [dlm_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [dlm_pkg::CFG_W-1:0] cfg_data_i,
  input  logic [dlm_pkg::CMD_W-1:0] in_cmd_i,
  input  logic [dlm_pkg::ROW_W-1:0] in_row_i,
  input  logic [dlm_pkg::COL_W-1:0] in_col_i,
  input  logic [dlm_pkg::VAL_W-1:0] in_value_i,
  input  dlm_pkg::dlm_cmd_t         cmd_i,
  output dlm_pkg::dlm_sts_t         sts_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [dlm_pkg::ROW_W-1:0] out_row_o,
  output logic [dlm_pkg::OUT_W-1:0] out_value_o,
  output logic                      out_status_o,
  output logic                      out_last_o
);
  import dlm_pkg::*;

  // configuration
  logic [CFG_W-1:0] rows_q, cols_q;
  logic [CFG_W-1:0] nrows;

  // vector state
  logic signed [ACC_W-1:0] acc_q [MAX_ROWS];
  logic [VAL_W-1:0]        bias_q [MAX_ROWS];
  logic [CNT_W-1:0]        cnt_q;
  logic [CNT_W-1:0]        cnt_inc;
  logic signed [VAL_W-1:0] x_q;

  // mac pipeline
  logic                     s1_valid_q;
  logic [ROW_W-1:0]         s1_row_q;
  logic                     p_valid_q;
  logic [ROW_W-1:0]         p_row_q;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic [VAL_W-1:0]         w_rdata;

  // weight write and read addressing
  logic               w_we;
  logic [WADDR_W-1:0] w_waddr, w_raddr;

  // result path
  logic signed [ACC_W-1:0] bias_ext, sum;
  logic [OUT_W-1:0]        sat;
  logic                    sum_fits;
  logic                    out_free;

  logic                    m_valid_q;
  logic [ROW_W-1:0]        m_row_q;
  logic [OUT_W-1:0]        m_value_q;
  logic                    m_status_q;
  logic                    m_last_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RST;
      cols_q <= COLS_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_ROWS) begin
        rows_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_COLS) begin
        cols_q <= cfg_data_i;
      end
    end
  end

  // active row count, clamped to the supported range
  always_comb begin
    if (rows_q == '0) begin
      nrows = CFG_W'(1);
    end else if (32'(rows_q) > ROW_LIM) begin
      nrows = CFG_W'(ROW_LIM);
    end else begin
      nrows = rows_q;
    end
  end

  // weight ram, written straight from a weight request
  assign w_we    = cmd_i.take && (in_cmd_i == CMD_WEIGHT) &&
                   (32'(in_row_i) < MAX_ROWS) && (32'(in_col_i) < MAX_COLS);
  assign w_waddr = WADDR_W'(32'(in_row_i) * MAX_COLS + 32'(in_col_i));
  assign w_raddr = WADDR_W'(32'(cmd_i.row) * MAX_COLS + 32'(cnt_q));

  dlm_ram #(
    .WIDTH(VAL_W),
    .DEPTH(WDEPTH)
  ) u_wram (
    .clk_i  (clk_i),
    .we_i   (w_we),
    .waddr_i(w_waddr),
    .wdata_i(in_value_i),
    .raddr_i(w_raddr),
    .rdata_o(w_rdata)
  );

  // vector element register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_x) begin
      x_q <= $signed(in_value_i);
    end
  end

  // multiply stage
  assign prod_d = $signed(w_rdata) * x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      p_valid_q  <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.acc_issue;
      p_valid_q  <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_row_q <= cmd_i.row;
    p_row_q  <= s1_row_q;
    prod_q   <= prod_d;
  end

  // saturating element count
  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;

  // accumulators, element count and bias store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_ROWS; i++) begin
        acc_q[i]  <= '0;
        bias_q[i] <= '0;
      end
      cnt_q <= '0;
    end else begin
      if (cmd_i.vec_clear) begin
        for (int i = 0; i < MAX_ROWS; i++) begin
          acc_q[i] <= '0;
        end
        cnt_q <= '0;
      end else begin
        if (p_valid_q) begin
          acc_q[p_row_q] <= acc_q[p_row_q] + ACC_W'(prod_q);
        end
        if (cmd_i.cnt_inc) begin
          cnt_q <= cnt_inc;
        end
      end
      if (cmd_i.take && (in_cmd_i == CMD_BIAS) && (32'(in_row_i) < MAX_ROWS)) begin
        bias_q[in_row_i] <= in_value_i;
      end
    end
  end

  // row sum plus aligned bias, saturated to the output range
  assign bias_ext = {{(ACC_W - VAL_W - FRAC_SHIFT){bias_q[cmd_i.row][VAL_W-1]}},
                     bias_q[cmd_i.row], {FRAC_SHIFT{1'b0}}};
  assign sum      = acc_q[cmd_i.row] + bias_ext;
  assign sum_fits = (&sum[ACC_W-1:OUT_W-1]) || !(|sum[ACC_W-1:OUT_W-1]);
  assign sat      = sum_fits ? sum[OUT_W-1:0] :
                    (sum[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}});

  // output register
  assign out_free = !m_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      m_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      m_row_q    <= cmd_i.out_mism ? '0 : cmd_i.row;
      m_value_q  <= cmd_i.out_mism ? '0 : sat;
      m_status_q <= cmd_i.out_mism;
      m_last_q   <= cmd_i.out_last;
    end
  end

  // status to the controller
  assign sts_o.acc_en    = (cnt_q < cols_q) && (32'(cnt_q) < MAX_COLS);
  assign sts_o.pipe_busy = s1_valid_q || p_valid_q;
  assign sts_o.match     = (cnt_inc == cols_q) && (cols_q != '0) &&
                           (32'(cols_q) <= MAX_COLS);
  assign sts_o.out_free  = out_free;
  assign sts_o.last_row  = ROW_W'(nrows - 1'b1);

  assign out_valid_o  = m_valid_q;
  assign out_row_o    = m_row_q;
  assign out_value_o  = m_value_q;
  assign out_status_o = m_status_q;
  assign out_last_o   = m_last_q;

`ifndef SYNTH
  // a result never overwrites one still waiting
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!m_valid_q || out_ready_i))
    else $error("result loaded over a pending result");

  // accumulators are cleared only with the mac pipeline empty
  a_clear_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.vec_clear |-> !(s1_valid_q || p_valid_q))
    else $error("vector cleared while products in flight");

  // products are issued only for an element inside the column range
  a_issue_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.acc_issue |-> ((cnt_q < cols_q) && (32'(cnt_q) < MAX_COLS)))
    else $error("mac issued for surplus element");

  // results are only produced with the pipeline drained
  a_emit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(s1_valid_q || p_valid_q))
    else $error("result emitted while accumulating");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/dense_layer_matvec_top.sv
// top level of the fully connected layer: y = W x + b in fixed point
// weight and bias requests are stored when taken, while the controller is idle
// a vector element drives one shared mac visiting one row accumulator per cycle, behind the
// registered weight ram read; a surplus element skips the mac; the last one then delivers
// one result per cycle while the output side takes them, or one beat on a count mismatch
// reset sets default config, clears biases, accumulators and control; weight ram is kept
`default_nettype none

module dense_layer_matvec_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [dlm_pkg::IDX_W-1:0]            cfg_index_i,
  input  logic [dlm_pkg::CFG_W-1:0]            cfg_data_i,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [dlm_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // row[3:0], col[7:4], value[23:8]
  input  logic [dlm_pkg::CMD_W-1:0]            s_axis_tuser,  // cmd[1:0]
  input  logic                                 s_axis_tlast,
  // result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [dlm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // out_row[3:0], out_value[35:4]
  output logic                                 m_axis_tuser,  // status[0]
  output logic                                 m_axis_tlast
);
  import dlm_pkg::*;

  dlm_cmd_t         cmd;
  dlm_sts_t         sts;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_col;
  logic [VAL_W-1:0] in_value;
  logic [ROW_W-1:0] out_row;
  logic [OUT_W-1:0] out_value;

  // unpack input data
  assign in_row   = s_axis_tdata[ROW_W-1:0];
  assign in_col   = s_axis_tdata[ROW_W+COL_W-1:ROW_W];
  assign in_value = s_axis_tdata[ROW_W+COL_W+VAL_W-1:ROW_W+COL_W];

  assign cfg_ready_o = 1'b1;

  dlm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_cmd_i  (s_axis_tuser),
    .in_last_i (s_axis_tlast),
    .in_ready_o(s_axis_tready),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  dlm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_cmd_i    (s_axis_tuser),
    .in_row_i    (in_row),
    .in_col_i    (in_col),
    .in_value_i  (in_value),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_row_o   (out_row),
    .out_value_o (out_value),
    .out_status_o(m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  // pack result data, zero filled to whole bytes
  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_W - ROW_W){1'b0}}, out_value, out_row};

endmodule

`default_nettype wire
